// File: hw/rtl/itbs_pkg.sv
package itbs_pkg;

  localparam int NUMBER_WIDTH_DEF = 32;
  localparam int MAX_BASE_DEF     = 16;

  localparam int CFG_WIDTH       = 64;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CHAR_WIDTH      = 8;
  localparam int BASE_LEN_WIDTH  = 5;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASE_LENGTH  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SYMBOLS_HIGH = 2'd2;

  localparam logic [BASE_LEN_WIDTH-1:0] BASE_LENGTH_RST  = 5'd10;
  localparam logic [CFG_WIDTH-1:0]      SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_WIDTH-1:0]      SYMBOLS_HIGH_RST = 64'h0000_0000_0000_4639;

  localparam logic [CHAR_WIDTH-1:0] MINUS_CHAR = 8'h2D;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

endpackage

// File: hw/rtl/integer_to_base_string.sv
// an input is taken only in the idle state, once the last character of the previous value
// has been loaded onto the output, so one value is converted at a time
// the magnitude shifts in one bit per cycle, msb first, through a row of radix digit cells
// characters then leave one per cycle while m_tready is high, sign first, most significant digit first
// rst is synchronous: the config registers return to base 10 and the default symbol bytes
// reset clears control state; no item is in flight after reset
module integer_to_base_string #(
  parameter int NUMBER_WIDTH = itbs_pkg::NUMBER_WIDTH_DEF,
  parameter int MAX_BASE     = itbs_pkg::MAX_BASE_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  input  logic [((NUMBER_WIDTH + 7) / 8) * 8 - 1:0]    s_tdata,   // value
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  output logic [itbs_pkg::CHAR_WIDTH-1:0]              m_tdata,   // out_char
  output logic                                         m_tlast,
  input  logic                                         cfg_we,
  input  logic [itbs_pkg::CFG_INDEX_WIDTH-1:0]         cfg_index,
  input  logic [itbs_pkg::CFG_WIDTH-1:0]               cfg_data
);
  import itbs_pkg::*;

  localparam int W  = NUMBER_WIDTH;
  localparam int DW = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;
  localparam int RW = $clog2(MAX_BASE + 1);
  localparam int CW = $clog2(W + 1);
  localparam int IW = $clog2(W);

  state_t state, state_next;

  logic [BASE_LEN_WIDTH-1:0] base_length;
  logic [CFG_WIDTH-1:0]      symbols_low;
  logic [CFG_WIDTH-1:0]      symbols_high;

  logic [W-1:0]  mag;
  logic [RW-1:0] radix;
  logic [DW-1:0] cells [W];
  logic [CW-1:0] cnt;
  logic [CW-1:0] bits;
  logic [IW-1:0] idx;
  logic          sign_pending;

  logic          take;
  logic          conv_step;
  logic          out_free;
  logic          emit_load;

  logic [RW-1:0] radix_use;
  logic [W-1:0]  raw;
  logic [W-1:0]  mag_in;
  logic [DW:0]   rad_e;
  logic [W-1:0]  gen;
  logic [W-1:0]  prop;
  logic [W:0]    sum;
  logic [W:0]    carries;
  logic [DW-1:0] cell_next [W];
  logic [CW-1:0] cnt_next;

  logic [2*CFG_WIDTH-1:0] syms;
  logic [DW-1:0]          dig;
  logic [3:0]             sym_idx;
  logic [CHAR_WIDTH-1:0]  sym;

  // radix clamp
  always_comb begin
    if (base_length < BASE_LEN_WIDTH'(2)) begin
      radix_use = RW'(2);
    end else if (base_length > BASE_LEN_WIDTH'(MAX_BASE)) begin
      radix_use = RW'(MAX_BASE);
    end else begin
      radix_use = base_length[RW-1:0];
    end
  end

  assign raw    = s_tdata[W-1:0];
  assign mag_in = raw[W-1] ? (~raw + W'(1)) : raw;

  // digit cells: double each digit and add the carry from below
  assign rad_e = (DW + 1)'(radix);

  always_comb begin
    for (int i = 0; i < W; i++) begin
      gen[i]  = ({cells[i], 1'b0} >= rad_e);
      prop[i] = ({cells[i], 1'b1} == rad_e);
    end
  end

  // carry chain as an add of generate and generate-or-propagate
  assign sum     = {1'b0, gen | prop} + {1'b0, gen} + (W + 1)'(mag[W-1]);
  assign carries = sum ^ {1'b0, gen | prop} ^ {1'b0, gen};

  always_comb begin
    for (int i = 0; i < W; i++) begin
      cell_next[i] = DW'({cells[i], carries[i]} - (carries[i+1] ? rad_e : (DW + 1)'(0)));
    end
  end

  assign cnt_next = (cnt < CW'(W) && carries[cnt]) ? cnt + CW'(1) : cnt;

  // symbol lookup
  assign syms    = {symbols_high, symbols_low};
  assign dig     = cells[idx];
  assign sym_idx = 4'(dig);
  assign sym     = syms[{sym_idx, 3'b000} +: CHAR_WIDTH];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bits == CW'(1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && !sign_pending && idx == IW'(0)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready  = 1'b0;
    conv_step = 1'b0;
    emit_load = 1'b0;
    case (state)
      ST_IDLE: s_tready  = 1'b1;
      ST_CONV: conv_step = 1'b1;
      ST_EMIT: emit_load = out_free;
      default: s_tready  = 1'b0;
    endcase
  end

  assign take     = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      base_length  <= BASE_LENGTH_RST;
      symbols_low  <= SYMBOLS_LOW_RST;
      symbols_high <= SYMBOLS_HIGH_RST;
      cnt          <= '0;
      bits         <= '0;
      sign_pending <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_LENGTH:  base_length  <= cfg_data[BASE_LEN_WIDTH-1:0];
          REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
          REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
          default: ;
        endcase
      end

      if (take) begin
        mag          <= mag_in;
        sign_pending <= raw[W-1];
        radix        <= radix_use;
        cnt          <= CW'(1);
        bits         <= CW'(W);
        for (int i = 0; i < W; i++) begin
          cells[i] <= '0;
        end
      end

      if (conv_step) begin
        mag  <= mag << 1;
        cnt  <= cnt_next;
        bits <= bits - CW'(1);
        idx  <= IW'(cnt_next - CW'(1));
        for (int i = 0; i < W; i++) begin
          cells[i] <= cell_next[i];
        end
      end

      if (emit_load) begin
        m_tvalid <= 1'b1;
        if (sign_pending) begin
          m_tdata      <= MINUS_CHAR;
          m_tlast      <= 1'b0;
          sign_pending <= 1'b0;
        end else begin
          m_tdata <= sym;
          m_tlast <= (idx == IW'(0));
          idx     <= idx - IW'(1);
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_start_clean: assert property (@(posedge clk) disable iff (rst)
    take |=> (state == ST_CONV) && (cnt == CW'(1)))
    else $error("conversion did not start from one digit");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> ((CW)'(idx) < cnt))
    else $error("emit pointer beyond digit count");

  a_radix_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> (radix >= RW'(2)) && (radix <= RW'(MAX_BASE)))
    else $error("radix out of range during conversion");

  a_sign_first: assert property (@(posedge clk) disable iff (rst)
    (emit_load && sign_pending) |=> (m_tdata == MINUS_CHAR) && !m_tlast && m_tvalid)
    else $error("minus sign not presented");
`endif

endmodule
